// ===== src/sparse_table_range_min_core_defines.svh =====
// Assertion macros shared by the range-minimum core.
`ifndef SPARSE_TABLE_RANGE_MIN_CORE_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MIN_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define STM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/stm_pkg.sv =====
package stm_pkg;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 10;
   localparam int SPAN_W  = INDEX_W + 1;
   localparam int LOG_W   = 4;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_B_LVL = 8'b0000_0010,
      ST_B_RA  = 8'b0000_0100,
      ST_B_RB  = 8'b0000_1000,
      ST_B_WR  = 8'b0001_0000,
      ST_Q_RA  = 8'b0010_0000,
      ST_Q_RB  = 8'b0100_0000,
      ST_Q_RES = 8'b1000_0000
   } state_type;

   // Position of the highest set bit of a nonzero span.
   function automatic logic [LOG_W-1:0] floor_log2(input logic [SPAN_W-1:0] v);
      logic [LOG_W-1:0] r;
      r = '0;
      for (int i = 0; i < SPAN_W; i++) begin
         if (v[i]) begin
            r = LOG_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== src/stm_ram.sv =====
module stm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sparse_table_range_min_core.sv =====
// A load word is written into the table as it is taken, if there is room. A query that
// passes the range check reads its two entries in ST_Q_RA and ST_Q_RB on the single table
// read port and registers its result in ST_Q_RES; a failed query goes straight to ST_Q_RES.
// No word is accepted until the query has left ST_Q_RES, and a stalled result holds the next
// query's result there until it leaves. A load flagged last starts a build with ST_B_RA,
// ST_B_RB and ST_B_WR per entry and ST_B_LVL per level and at the end; it accepts no word.
// Reset clears the control state, the element count, the built flag and the result valid
// flag; the table memory keeps its contents and is rewritten by the next loads and build.
`include "sparse_table_range_min_core_defines.svh"

module sparse_table_range_min_core #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS       = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic signed [stm_pkg::VALUE_W-1:0]  req_element_value,
   input  logic                                req_last_element,
   input  logic        [stm_pkg::INDEX_W-1:0]  req_left_index,
   input  logic        [stm_pkg::INDEX_W-1:0]  req_right_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [stm_pkg::VALUE_W-1:0]  rsp_range_minimum,
   output logic                                rsp_status
);

   localparam int DEPTH = LEVELS * MAX_ELEMENTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_ELEMENTS + 1);
   localparam int LVW   = $clog2(LEVELS + 1);
   localparam int HW    = LEVELS - 1;
   localparam int VW    = stm_pkg::VALUE_W;
   localparam int SW    = stm_pkg::SPAN_W;
   localparam int KW    = stm_pkg::LOG_W;

   stm_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           ready_ff, ready_in;
   logic [LVW-1:0] lvl_ff, lvl_in;
   logic [HW-1:0]  half_ff, half_in;
   logic [AW-1:0]  base_ff, base_in;
   logic [CW-1:0]  j_ff, j_in;
   logic [AW-1:0]  addr_a_ff, addr_a_in;
   logic [AW-1:0]  addr_b_ff, addr_b_in;
   logic           err_ff, err_in;
   logic signed [VW-1:0] a_ff, a_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0] rsp_min_ff, rsp_min_in;
   logic           rsp_status_ff, rsp_status_in;

   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [VW-1:0]  wr_data;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic [VW-1:0]  rd_data;

   logic                         accept;
   logic [stm_pkg::INDEX_W-1:0]  q_lo;
   logic [stm_pkg::INDEX_W-1:0]  q_hi;
   logic [SW-1:0]                q_len;
   logic [KW-1:0]                q_k;
   logic [KW-1:0]                q_kc;
   logic [SW-1:0]                q_start_b;
   logic                         q_err;
   logic [CW-1:0]                load_cnt;
   logic signed [VW-1:0]         min_ab;
   logic                         out_free;

   stm_ram #(
      .WIDTH(VW),
      .DEPTH(DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_stall = (state_ff != stm_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign min_ab    = (a_ff < $signed(rd_data)) ? a_ff : $signed(rd_data);

   always_comb begin
      if (req_left_index > req_right_index) begin
         q_lo = req_right_index;
         q_hi = req_left_index;
      end else begin
         q_lo = req_left_index;
         q_hi = req_right_index;
      end
      q_len     = SW'(q_hi) - SW'(q_lo) + SW'(1);
      q_k       = stm_pkg::floor_log2(q_len);
      q_kc      = (int'(q_k) > LEVELS - 1) ? KW'(LEVELS - 1) : q_k;
      q_start_b = SW'(q_hi) + SW'(1) - (SW'(1) << q_kc);
      q_err     = !ready_ff || (32'(q_hi) >= 32'(cnt_ff)) || (32'(q_hi) >= MAX_ELEMENTS);
      load_cnt  = ready_ff ? '0 : cnt_ff;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ready_in      = ready_ff;
      lvl_in        = lvl_ff;
      half_in       = half_ff;
      base_in       = base_ff;
      j_in          = j_ff;
      addr_a_in     = addr_a_ff;
      addr_b_in     = addr_b_ff;
      err_in        = err_ff;
      a_in          = a_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_min_in    = rsp_min_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = base_ff + AW'(MAX_ELEMENTS) + AW'(j_ff);
      wr_data       = min_ab;
      rd_en         = 1'b0;
      rd_addr       = addr_a_ff;

      unique case (state_ff)
         stm_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_kind == stm_pkg::KIND_LOAD) begin
                  ready_in = 1'b0;
                  cnt_in   = load_cnt;
                  if (load_cnt < CW'(MAX_ELEMENTS)) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(load_cnt);
                     wr_data = req_element_value;
                     cnt_in  = load_cnt + CW'(1);
                  end
                  if (req_last_element) begin
                     lvl_in   = LVW'(1);
                     half_in  = HW'(1);
                     base_in  = '0;
                     state_in = stm_pkg::ST_B_LVL;
                  end
               end else begin
                  err_in    = q_err;
                  addr_a_in = AW'(q_kc) * AW'(MAX_ELEMENTS) + AW'(q_lo);
                  addr_b_in = AW'(q_kc) * AW'(MAX_ELEMENTS) + AW'(q_start_b);
                  state_in  = q_err ? stm_pkg::ST_Q_RES : stm_pkg::ST_Q_RA;
               end
            end
         end
         stm_pkg::ST_B_LVL: begin
            j_in = '0;
            if ((lvl_ff == LVW'(LEVELS)) || (32'(half_ff) >= 32'(cnt_ff))) begin
               ready_in = 1'b1;
               state_in = stm_pkg::ST_IDLE;
            end else begin
               state_in = stm_pkg::ST_B_RA;
            end
         end
         stm_pkg::ST_B_RA: begin
            rd_en    = 1'b1;
            rd_addr  = base_ff + AW'(j_ff);
            state_in = stm_pkg::ST_B_RB;
         end
         stm_pkg::ST_B_RB: begin
            rd_en    = 1'b1;
            rd_addr  = base_ff + AW'(j_ff) + AW'(half_ff);
            a_in     = rd_data;
            state_in = stm_pkg::ST_B_WR;
         end
         stm_pkg::ST_B_WR: begin
            wr_en = 1'b1;
            j_in  = j_ff + CW'(1);
            if (32'(j_ff) + 32'd1 + 32'(half_ff) < 32'(cnt_ff)) begin
               state_in = stm_pkg::ST_B_RA;
            end else begin
               lvl_in   = lvl_ff + LVW'(1);
               half_in  = half_ff << 1;
               base_in  = base_ff + AW'(MAX_ELEMENTS);
               state_in = stm_pkg::ST_B_LVL;
            end
         end
         stm_pkg::ST_Q_RA: begin
            rd_en    = 1'b1;
            rd_addr  = addr_a_ff;
            state_in = stm_pkg::ST_Q_RB;
         end
         stm_pkg::ST_Q_RB: begin
            rd_en    = 1'b1;
            rd_addr  = addr_b_ff;
            a_in     = rd_data;
            state_in = stm_pkg::ST_Q_RES;
         end
         stm_pkg::ST_Q_RES: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_min_in    = err_ff ? '0 : min_ab;
               rsp_status_in = err_ff ? stm_pkg::STATUS_ERR : stm_pkg::STATUS_OK;
               state_in      = stm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stm_pkg::ST_IDLE;
         cnt_ff       <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff        <= lvl_in;
      half_ff       <= half_in;
      base_ff       <= base_in;
      j_ff          <= j_in;
      addr_a_ff     <= addr_a_in;
      addr_b_ff     <= addr_b_in;
      err_ff        <= err_in;
      a_ff          <= a_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_range_minimum = rsp_min_ff;
   assign rsp_status        = rsp_status_ff;

   `STM_ASSERT_SAME(a_no_same_entry, wr_en && rd_en, wr_addr != rd_addr,
      "Table read and write hit the same entry in one cycle.")
   `STM_ASSERT_NEXT(a_query_path, accept && (req_kind == stm_pkg::KIND_QUERY),
      (state_ff == stm_pkg::ST_Q_RA) || (state_ff == stm_pkg::ST_Q_RES),
      "An accepted query did not start its table reads.")
   `STM_ASSERT_SAME(a_ready_from_build, $rose(ready_ff),
      $past(state_ff) == stm_pkg::ST_B_LVL,
      "The table was marked built outside the end of a build.")
   `STM_ASSERT_SAME(a_err_zero, rsp_valid_ff && (rsp_status_ff == stm_pkg::STATUS_ERR),
      rsp_min_ff == '0,
      "A failed query word carries a nonzero minimum.")

endmodule
